[sv/xpt_pkg.sv]
`timescale 1ns / 1ps
// shared types, constants and a function of the crosspoint matrix block
package xpt_pkg;

    localparam int LINES     = 16;
    localparam int LINE_W    = $clog2(LINES);
    localparam int SEL_W     = 4;
    localparam int ROW_W     = 16;
    localparam int MAP_W     = 64;
    localparam int CFG_IDX_W = 2;
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_X_MAP = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_Y_MAP = CFG_IDX_W'(1);

    localparam logic [MAP_W-1:0] IDENTITY_MAP = 64'hFEDC_BA98_7654_3210;

    typedef enum logic [1:0] {
        OP_CONNECT = 2'd0,
        OP_QUERY   = 2'd1,
        OP_CLEAR   = 2'd2,
        OP_FLUSH   = 2'd3
    } t_op;

    typedef enum logic {
        BK_IDLE,
        BK_FLUSH
    } t_back_state;

    typedef struct packed {
        t_op              op;
        logic [SEL_W-1:0] px;
        logic [SEL_W-1:0] py;
        logic             usable;
        logic             err;
    } t_cmd;

    typedef struct packed {
        logic not_empty;
        logic full;
    } t_queue_status;

    // a table is good when its first LINES entries are in range and hit every line
    function automatic logic map_valid(input logic [MAP_W-1:0] table_bits);
        logic             ok;
        logic             found;
        logic [SEL_W-1:0] e;
        ok = 1'b1;
        for (int i = 0; i < LINES; i++) begin
            e = table_bits[i*SEL_W +: SEL_W];
            if (int'(e) >= LINES) begin
                ok = 1'b0;
            end
        end
        for (int v = 0; v < LINES; v++) begin
            found = 1'b0;
            for (int i = 0; i < LINES; i++) begin
                if (table_bits[i*SEL_W +: SEL_W] == SEL_W'(v)) begin
                    found = 1'b1;
                end
            end
            if (!found) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

[sv/xpt_front.sv]
`timescale 1ns / 1ps
// front end: mapping tables, command accept and classification
module xpt_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [1:0]                     i_operation,
    input  logic [xpt_pkg::SEL_W-1:0]      i_x_line,
    input  logic [xpt_pkg::SEL_W-1:0]      i_y_line,
    input  logic                           i_cfg_valid,
    input  logic [xpt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [xpt_pkg::MAP_W-1:0]      i_cfg_data,
    input  xpt_pkg::t_queue_status         i_qstat,
    output logic                           o_push,
    output xpt_pkg::t_cmd                  o_cmd
);

    logic [xpt_pkg::MAP_W-1:0] r_x_map;
    logic [xpt_pkg::MAP_W-1:0] r_y_map;
    logic                      r_x_ok;
    logic                      r_y_ok;
    logic                      err;
    logic                      in_range;

    // validity is worked out once, as the table is written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_map <= xpt_pkg::IDENTITY_MAP;
            r_y_map <= xpt_pkg::IDENTITY_MAP;
            r_x_ok  <= 1'b1;
            r_y_ok  <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                xpt_pkg::CFG_X_MAP: begin
                    r_x_map <= i_cfg_data;
                    r_x_ok  <= xpt_pkg::map_valid(i_cfg_data);
                end
                xpt_pkg::CFG_Y_MAP: begin
                    r_y_map <= i_cfg_data;
                    r_y_ok  <= xpt_pkg::map_valid(i_cfg_data);
                end
                default: begin
                end
            endcase
        end
    end

    assign err      = !(r_x_ok && r_y_ok);
    assign in_range = (int'(i_x_line) < xpt_pkg::LINES) && (int'(i_y_line) < xpt_pkg::LINES);

    always_comb begin
        o_push        = i_start && !i_qstat.full;
        o_cmd.op      = xpt_pkg::t_op'(i_operation);
        o_cmd.px      = r_x_map[{i_x_line, 2'b00} +: xpt_pkg::SEL_W];
        o_cmd.py      = r_y_map[{i_y_line, 2'b00} +: xpt_pkg::SEL_W];
        o_cmd.usable  = !err && in_range;
        o_cmd.err     = err;
    end

endmodule

[sv/xpt_queue.sv]
`timescale 1ns / 1ps
// short command queue between front and back
module xpt_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  xpt_pkg::t_cmd          i_cmd,
    input  logic                   i_pop,
    output xpt_pkg::t_cmd          o_cmd,
    output xpt_pkg::t_queue_status o_stat
);

    xpt_pkg::t_cmd                r_mem [xpt_pkg::QDEPTH];
    logic [xpt_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [xpt_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [xpt_pkg::QCNT_W-1:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + xpt_pkg::QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + xpt_pkg::QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + xpt_pkg::QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - xpt_pkg::QCNT_W'(1);
            end
        end
    end

    assign o_cmd            = r_mem[r_rd_ptr];
    assign o_stat.not_empty = (r_count != '0);
    assign o_stat.full      = (r_count == xpt_pkg::QCNT_W'(xpt_pkg::QDEPTH));

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.full |-> !i_push)
        else $error("push into a full command queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_stat.not_empty |-> !i_pop)
        else $error("pop from an empty command queue");

endmodule

[sv/xpt_back.sv]
`timescale 1ns / 1ps
// back end: switch matrix, command execution and result registers
module xpt_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  xpt_pkg::t_queue_status     i_qstat,
    input  xpt_pkg::t_cmd              i_cmd,
    output logic                       o_pop,
    output logic                       o_strobe,
    output logic                       o_connected,
    output logic [xpt_pkg::SEL_W-1:0]  o_row_index,
    output logic [xpt_pkg::ROW_W-1:0]  o_row_bits,
    output logic                       o_latch,
    output logic                       o_last,
    output logic                       o_map_error
);

    xpt_pkg::t_back_state       r_state;
    xpt_pkg::t_back_state       n_state;
    logic [xpt_pkg::LINES-1:0]  r_matrix [xpt_pkg::LINES];
    logic [xpt_pkg::LINE_W-1:0] r_row;
    logic [xpt_pkg::LINE_W-1:0] n_row;
    logic                       r_err;
    logic                       n_err;
    logic [xpt_pkg::LINE_W-1:0] pxi;
    logic [xpt_pkg::LINE_W-1:0] pyi;
    logic                       do_connect;
    logic                       do_clear;
    logic                       n_strobe;
    logic                       n_connected;
    logic [xpt_pkg::SEL_W-1:0]  n_row_index;
    logic [xpt_pkg::ROW_W-1:0]  n_row_bits;
    logic                       n_latch;
    logic                       n_last;
    logic                       n_map_error;

    assign pxi = i_cmd.px[xpt_pkg::LINE_W-1:0];
    assign pyi = i_cmd.py[xpt_pkg::LINE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= xpt_pkg::BK_IDLE;
            r_row   <= '0;
            r_err   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_err   <= n_err;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_err       = r_err;
        o_pop       = 1'b0;
        do_connect  = 1'b0;
        do_clear    = 1'b0;
        n_strobe    = 1'b0;
        n_connected = 1'b0;
        n_row_index = '0;
        n_row_bits  = '0;
        n_latch     = 1'b0;
        n_last      = 1'b0;
        n_map_error = 1'b0;
        unique case (r_state)
            xpt_pkg::BK_IDLE: begin
                if (i_qstat.not_empty) begin
                    o_pop       = 1'b1;
                    n_map_error = i_cmd.err;
                    case (i_cmd.op)
                        xpt_pkg::OP_CONNECT: begin
                            do_connect = i_cmd.usable;
                            n_strobe   = 1'b1;
                            n_last     = 1'b1;
                        end
                        xpt_pkg::OP_QUERY: begin
                            n_connected = i_cmd.usable && r_matrix[pyi][pxi];
                            n_strobe    = 1'b1;
                            n_last      = 1'b1;
                        end
                        xpt_pkg::OP_CLEAR: begin
                            do_clear = 1'b1;
                            n_strobe = 1'b1;
                            n_last   = 1'b1;
                        end
                        default: begin
                            // flush: words follow from the top row down
                            n_state = xpt_pkg::BK_FLUSH;
                            n_row   = xpt_pkg::LINE_W'(xpt_pkg::LINES - 1);
                            n_err   = i_cmd.err;
                        end
                    endcase
                end
            end
            xpt_pkg::BK_FLUSH: begin
                n_strobe    = 1'b1;
                n_row_index = xpt_pkg::SEL_W'(r_row);
                n_row_bits  = xpt_pkg::ROW_W'(r_matrix[r_row]);
                n_map_error = r_err;
                n_row       = r_row - xpt_pkg::LINE_W'(1);
                if (r_row == '0) begin
                    n_latch = 1'b1;
                    n_last  = 1'b1;
                    n_state = xpt_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = xpt_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < xpt_pkg::LINES; r++) begin
                r_matrix[r] <= '0;
            end
        end else if (do_clear) begin
            for (int r = 0; r < xpt_pkg::LINES; r++) begin
                r_matrix[r] <= '0;
            end
        end else if (do_connect) begin
            r_matrix[pyi][pxi] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= n_strobe;
        end
        o_connected <= n_connected;
        o_row_index <= n_row_index;
        o_row_bits  <= n_row_bits;
        o_latch     <= n_latch;
        o_last      <= n_last;
        o_map_error <= n_map_error;
    end

    a_flush_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |=> o_strobe)
        else $error("flush words not back to back");

    a_flush_row_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |=> o_row_index == $past(o_row_index) - xpt_pkg::SEL_W'(1))
        else $error("flush rows out of order");

    a_no_pop_in_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == xpt_pkg::BK_FLUSH |-> !o_pop)
        else $error("command taken while a flush runs");

endmodule

[sv/crosspoint_matrix_config_serializer.sv]
`timescale 1ns / 1ps
// top level of the crosspoint matrix with serial row words
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+---------------------------------------------
//  command   | start in, busy out         | i_operation, i_x_line, i_y_line
//  result    | o_strobe out, no stall     | o_connected, o_row_index, o_row_bits,
//            |                            | o_latch, o_last, o_map_error
//  config    | i_cfg_valid, o_cfg_ready   | i_cfg_index, i_cfg_data
//
// a command is taken while busy is low; busy rises when the two-entry command queue is full
// connect, query and clear give their one result after the command queue and the back-end output registers
// flush is dispatched by the idle back end, then gives one row word per cycle, row 15 first
// the back end runs one command at a time, so a flush holds later commands in the queue
// i_rst_n is synchronous: on it the matrix clears and both tables return to identity
module crosspoint_matrix_config_serializer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     i_operation,
    input  logic [xpt_pkg::SEL_W-1:0]      i_x_line,
    input  logic [xpt_pkg::SEL_W-1:0]      i_y_line,
    output logic                           o_strobe,
    output logic                           o_connected,
    output logic [xpt_pkg::SEL_W-1:0]      o_row_index,
    output logic [xpt_pkg::ROW_W-1:0]      o_row_bits,
    output logic                           o_latch,
    output logic                           o_last,
    output logic                           o_map_error,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [xpt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [xpt_pkg::MAP_W-1:0]      i_cfg_data
);

    xpt_pkg::t_queue_status qstat;
    xpt_pkg::t_cmd          push_cmd;
    xpt_pkg::t_cmd          head_cmd;
    logic                   push;
    logic                   pop;

    assign busy        = qstat.full;
    assign o_cfg_ready = 1'b1;

    xpt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_operation (i_operation),
        .i_x_line    (i_x_line),
        .i_y_line    (i_y_line),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_qstat     (qstat),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    xpt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_stat  (qstat)
    );

    xpt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_qstat     (qstat),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .o_strobe    (o_strobe),
        .o_connected (o_connected),
        .o_row_index (o_row_index),
        .o_row_bits  (o_row_bits),
        .o_latch     (o_latch),
        .o_last      (o_last),
        .o_map_error (o_map_error)
    );

endmodule
